/* hdl/tcw_pkg.sv */
// tcw_pkg: shared types and constants of the text console writer
// no dependencies; used by tcw_ctrl and text_console_writer_unit

package tcw_pkg;

  // field widths of the stream items
  localparam int KIND_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int INDEX_W = 11;
  localparam int POS_W   = 11;
  localparam int CELL_W  = 16;
  localparam int ATTR_W  = 8;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // character codes with special handling
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;

  // configuration register indexes and reset values
  localparam logic REG_TEXT_ATTR  = 1'b0;
  localparam logic REG_BLANK_ATTR = 1'b1;
  localparam logic [ATTR_W-1:0] RESET_TEXT_ATTR  = 8'h0F;
  localparam logic [ATTR_W-1:0] RESET_BLANK_ATTR = 8'h07;

  // configuration handed to the controller
  typedef struct packed {
    logic [ATTR_W-1:0] text_attr;
    logic [ATTR_W-1:0] blank_attr;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic [CELL_W-1:0] cell_data;
    logic [POS_W-1:0]  cursor_pos;
  } result_t;

endpackage

/* hdl/tcw_ram.sv */
// tcw_ram: screen cell store, one write port and one registered read port
// no dependencies

module tcw_ram #(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/tcw_ctrl.sv */
// tcw_ctrl: cursor, row-base pointer and blanking sweeps around the cell store
// depends on tcw_pkg and tcw_ram

module tcw_ctrl #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tcw_pkg::KIND_W-1:0]   in_kind,
  input  logic [tcw_pkg::CHAR_W-1:0]   in_char,
  input  logic [tcw_pkg::INDEX_W-1:0]  in_index,
  input  tcw_pkg::cfg_t                cfg,
  output logic                         res_valid,
  input  logic                         res_ready,
  output tcw_pkg::result_t             res
);

  localparam int CELLS        = COLUMNS * ROWS;
  localparam int ADDR_W       = $clog2(CELLS);
  localparam int COL_W        = $clog2(COLUMNS);
  localparam int ROW_W        = $clog2(ROWS);
  localparam int LAST_ROW_LIN = (ROWS - 1) * COLUMNS;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SWEEP  = 2'd1;
  localparam logic [1:0] ST_RDWAIT = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0]                       state;
  logic [ADDR_W-1:0]                lin;
  logic [COL_W-1:0]                 col;
  logic [ROW_W-1:0]                 row;
  logic [ADDR_W-1:0]                base_off;
  logic [ADDR_W-1:0]                sweep_addr;
  logic [ADDR_W-1:0]                sweep_end;
  logic [tcw_pkg::CELL_W-1:0]       sweep_cell;
  logic                             sweep_reply;
  logic                             rd_ok;
  logic [tcw_pkg::CELL_W-1:0]       res_data;

  logic                             accept;
  logic                             is_put;
  logic                             is_nl;
  logic                             is_bs;
  logic                             col_last;
  logic                             row_last;
  logic                             row_advance;
  logic                             idx_ok;
  logic [ADDR_W-1:0]                cur_phys;
  logic [ADDR_W-1:0]                idx_phys;
  logic [ADDR_W:0]                  nb_sum;
  logic [ADDR_W-1:0]                next_base;
  logic [tcw_pkg::CELL_W-1:0]       blank_cell;
  logic [ADDR_W+10:0]               pos_wide;

  logic                             mem_we;
  logic [ADDR_W-1:0]                mem_waddr;
  logic [tcw_pkg::CELL_W-1:0]       mem_wdata;
  logic                             mem_re;
  logic [ADDR_W-1:0]                mem_raddr;
  logic [tcw_pkg::CELL_W-1:0]       mem_rdata;

  // logical cell position to physical address through the row-base offset
  function automatic logic [ADDR_W-1:0] to_phys(input logic [ADDR_W-1:0] pos,
                                                input logic [ADDR_W-1:0] off);
    logic [ADDR_W:0] sum;
    sum = {1'b0, pos} + {1'b0, off};
    if (sum >= (ADDR_W+1)'(CELLS)) begin
      sum = sum - (ADDR_W+1)'(CELLS);
    end
    return sum[ADDR_W-1:0];
  endfunction

  tcw_ram #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W),
    .DATA_W (tcw_pkg::CELL_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // item decode
  assign in_ready    = (state == ST_IDLE);
  assign accept      = in_valid && in_ready;
  assign is_put      = (in_kind == tcw_pkg::KIND_PUT);
  assign is_nl       = (in_char == tcw_pkg::CHAR_NEWLINE);
  assign is_bs       = (in_char == tcw_pkg::CHAR_BACKSPACE);
  assign col_last    = (col == COL_W'(COLUMNS - 1));
  assign row_last    = (row == ROW_W'(ROWS - 1));
  assign row_advance = is_nl || (!is_bs && col_last);
  assign idx_ok      = (32'(in_index) < 32'(CELLS));
  assign blank_cell  = {cfg.blank_attr, tcw_pkg::CHAR_SPACE};

  // address translation
  assign cur_phys = to_phys(lin, base_off);
  assign idx_phys = to_phys(ADDR_W'(in_index), base_off);

  // row base after a scroll, wrapping around the store
  always_comb begin
    nb_sum = {1'b0, base_off} + (ADDR_W+1)'(COLUMNS);
    if (nb_sum >= (ADDR_W+1)'(CELLS)) begin
      nb_sum = nb_sum - (ADDR_W+1)'(CELLS);
    end
    next_base = nb_sum[ADDR_W-1:0];
  end

  // store write port: sweep or one cell of a put
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_phys;
    mem_wdata = blank_cell;
    if (state == ST_SWEEP) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_addr;
      mem_wdata = sweep_cell;
    end else if (accept && is_put && !is_nl) begin
      if (is_bs) begin
        mem_we    = (col != '0);
        mem_waddr = cur_phys - ADDR_W'(1);
        mem_wdata = blank_cell;
      end else begin
        mem_we    = 1'b1;
        mem_waddr = cur_phys;
        mem_wdata = {cfg.text_attr, in_char};
      end
    end
  end

  // store read port
  assign mem_re    = accept && (in_kind == tcw_pkg::KIND_READ) && idx_ok;
  assign mem_raddr = idx_phys;

  // sequencer and cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SWEEP;
      sweep_addr  <= '0;
      sweep_end   <= ADDR_W'(CELLS - 1);
      sweep_cell  <= {tcw_pkg::RESET_BLANK_ATTR, tcw_pkg::CHAR_SPACE};
      sweep_reply <= 1'b0;
      lin         <= '0;
      col         <= '0;
      row         <= '0;
      base_off    <= '0;
      rd_ok       <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            res_data <= '0;
            case (in_kind)
              tcw_pkg::KIND_PUT: begin
                if (row_advance) begin
                  col <= '0;
                  if (row_last) begin
                    lin         <= ADDR_W'(LAST_ROW_LIN);
                    base_off    <= next_base;
                    sweep_addr  <= base_off;
                    sweep_end   <= base_off + ADDR_W'(COLUMNS - 1);
                    sweep_cell  <= blank_cell;
                    sweep_reply <= 1'b1;
                    state       <= ST_SWEEP;
                  end else begin
                    row   <= row + ROW_W'(1);
                    lin   <= lin - ADDR_W'(col) + ADDR_W'(COLUMNS);
                    state <= ST_DONE;
                  end
                end else if (is_bs) begin
                  state <= ST_DONE;
                  if (col != '0) begin
                    col <= col - COL_W'(1);
                    lin <= lin - ADDR_W'(1);
                  end
                end else begin
                  state <= ST_DONE;
                  col   <= col + COL_W'(1);
                  lin   <= lin + ADDR_W'(1);
                end
              end
              tcw_pkg::KIND_CLEAR: begin
                lin         <= '0;
                col         <= '0;
                row         <= '0;
                base_off    <= '0;
                sweep_addr  <= '0;
                sweep_end   <= ADDR_W'(CELLS - 1);
                sweep_cell  <= blank_cell;
                sweep_reply <= 1'b1;
                state       <= ST_SWEEP;
              end
              tcw_pkg::KIND_READ: begin
                rd_ok <= idx_ok;
                state <= ST_RDWAIT;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_SWEEP: begin
          sweep_addr <= sweep_addr + ADDR_W'(1);
          if (sweep_addr == sweep_end) begin
            state <= sweep_reply ? ST_DONE : ST_IDLE;
          end
        end
        ST_RDWAIT: begin
          res_data <= rd_ok ? mem_rdata : '0;
          state    <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result toward the output stage
  assign pos_wide       = (ADDR_W+11)'(lin);
  assign res_valid      = (state == ST_DONE);
  assign res.cursor_pos = pos_wide[tcw_pkg::POS_W-1:0];
  assign res.cell_data  = res_data;

endmodule

/* hdl/text_console_writer_unit.sv */
// text_console_writer_unit: character-cell text console, top level
// depends on tcw_pkg and tcw_ctrl (which holds tcw_ram)
// a put goes straight to the done state, a read first waits for the registered store read,
// a scroll first blanks the old top row and a clear all COLUMNS*ROWS cells
// no new item is taken until the done state has handed the current result on
// reset: after rst the store is blanked one cell a cycle, all COLUMNS*ROWS cells,
// with s_tready low; configuration writes are taken throughout

module text_console_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] char_code, [18:8] cell_index
  input  logic [1:0]  s_tuser,   // [1:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [10:0] cursor_pos, [26:11] cell_data
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  tcw_pkg::cfg_t    cfg;
  tcw_pkg::result_t res;
  tcw_pkg::result_t out_res;
  logic             res_valid;
  logic             res_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.text_attr  <= tcw_pkg::RESET_TEXT_ATTR;
      cfg.blank_attr <= tcw_pkg::RESET_BLANK_ATTR;
    end else if (cfg_we) begin
      case (cfg_index)
        tcw_pkg::REG_TEXT_ATTR:  cfg.text_attr  <= cfg_data;
        tcw_pkg::REG_BLANK_ATTR: cfg.blank_attr <= cfg_data;
        default: ;
      endcase
    end
  end

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_kind   (s_tuser),
    .in_char   (s_tdata[7:0]),
    .in_index  (s_tdata[18:8]),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register: holds one result while the controller moves on
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {5'b0, out_res.cell_data, out_res.cursor_pos};

endmodule

/* dv/tb_text_console_writer_unit.sv */
// tb_text_console_writer_unit: self-checking testbench of the text console writer
// depends on tcw_pkg and text_console_writer_unit; a shadow screen predicts the results,
// typed table rows apart, of a directed table and random typing under several attributes

module tb_text_console_writer_unit;

  localparam int COLS        = 80;
  localparam int ROWS_N      = 25;
  localparam int CELLS       = COLS * ROWS_N;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 250;
  localparam int LONG_HOLD   = 400;
  localparam logic [tcw_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       s_tvalid  = 1'b0;
  logic                       s_tready;
  logic [23:0]                s_tdata   = '0;  // [7:0] char_code, [18:8] cell_index
  logic [1:0]                 s_tuser   = '0;  // [1:0] kind
  logic                       m_tvalid;
  logic                       m_tready  = 1'b0;
  logic [31:0]                m_tdata;         // [10:0] cursor_pos, [26:11] cell_data
  logic                       cfg_we    = 1'b0;
  logic                       cfg_index = 1'b0;
  logic [tcw_pkg::ATTR_W-1:0] cfg_data  = '0;

  // shadow copy of the console state
  logic [tcw_pkg::CELL_W-1:0] shadow_screen [CELLS];
  int                         cur_col;
  int                         cur_row;
  logic [tcw_pkg::ATTR_W-1:0] text_attr;
  logic [tcw_pkg::ATTR_W-1:0] blank_attr;

  tcw_pkg::result_t pending_results [$];
  int               error_count  = 0;
  int               results_seen = 0;
  int               cycle_count  = 0;
  bit               fast_mode    = 1'b0;

  // one row of the directed stimulus
  typedef struct {
    logic [tcw_pkg::KIND_W-1:0]  kind;
    logic [tcw_pkg::CHAR_W-1:0]  code;
    logic [tcw_pkg::INDEX_W-1:0] idx;
    bit                          typed;
    logic [tcw_pkg::POS_W-1:0]   pos;
    logic [tcw_pkg::CELL_W-1:0]  exp_cell;
  } stim_row_t;

  stim_row_t opening_items [23] = '{
    '{tcw_pkg::KIND_READ,  8'h00,                   11'd0,    1'b1, 11'd0, 16'h0720},
    '{tcw_pkg::KIND_READ,  8'h00,                   11'd1999, 1'b1, 11'd0, 16'h0720},
    '{tcw_pkg::KIND_READ,  8'h00,                   11'd2000, 1'b1, 11'd0, 16'h0000},
    '{tcw_pkg::KIND_READ,  8'hFF,                   11'd2047, 1'b1, 11'd0, 16'h0000},
    '{KIND_UNUSED,         8'hFF,                   11'd2047, 1'b1, 11'd0, 16'h0000},
    '{tcw_pkg::KIND_PUT,   tcw_pkg::CHAR_BACKSPACE, 11'd0,    1'b1, 11'd0, 16'h0000},
    '{tcw_pkg::KIND_PUT,   8'h41,                   11'd0,    1'b1, 11'd1, 16'h0000},
    '{tcw_pkg::KIND_READ,  8'h00,                   11'd0,    1'b1, 11'd1, 16'h0F41},
    '{tcw_pkg::KIND_PUT,   8'h00,                   11'd2047, 1'b0, 11'd0, 16'h0000},
    '{tcw_pkg::KIND_PUT,   8'hFF,                   11'd0,    1'b0, 11'd0, 16'h0000},
    '{tcw_pkg::KIND_PUT,   8'h80,                   11'd0,    1'b0, 11'd0, 16'h0000},
    '{tcw_pkg::KIND_READ,  8'h00,                   11'd2,    1'b0, 11'd0, 16'h0000},
    '{tcw_pkg::KIND_READ,  8'h00,                   11'd3,    1'b0, 11'd0, 16'h0000},
    '{tcw_pkg::KIND_PUT,   tcw_pkg::CHAR_BACKSPACE, 11'd0,    1'b0, 11'd0, 16'h0000},
    '{tcw_pkg::KIND_READ,  8'h00,                   11'd3,    1'b0, 11'd0, 16'h0000},
    '{tcw_pkg::KIND_PUT,   tcw_pkg::CHAR_NEWLINE,   11'd0,    1'b0, 11'd0, 16'h0000},
    '{tcw_pkg::KIND_PUT,   8'h7F,                   11'd0,    1'b0, 11'd0, 16'h0000},
    '{tcw_pkg::KIND_READ,  8'h00,                   11'd80,   1'b0, 11'd0, 16'h0000},
    '{tcw_pkg::KIND_CLEAR, 8'hFF,                   11'd2047, 1'b1, 11'd0, 16'h0000},
    '{tcw_pkg::KIND_READ,  8'h00,                   11'd0,    1'b1, 11'd0, 16'h0720},
    '{tcw_pkg::KIND_READ,  8'h00,                   11'd81,   1'b1, 11'd0, 16'h0720},
    '{tcw_pkg::KIND_PUT,   tcw_pkg::CHAR_SPACE,     11'd0,    1'b0, 11'd0, 16'h0000},
    '{tcw_pkg::KIND_READ,  8'h00,                   11'd0,    1'b0, 11'd0, 16'h0000}
  };

  text_console_writer_unit #(
    .COLUMNS(COLS),
    .ROWS   (ROWS_N)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // shadow screen helpers
  function automatic void blank_range(input int from, input int upto);
    for (int i = from; i < upto; i++) shadow_screen[i] = {blank_attr, tcw_pkg::CHAR_SPACE};
  endfunction

  function automatic void next_line();
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS_N) begin
      // scroll up one row and blank the bottom row
      cur_row = ROWS_N - 1;
      for (int i = 0; i < (ROWS_N - 1) * COLS; i++) shadow_screen[i] = shadow_screen[i + COLS];
      blank_range((ROWS_N - 1) * COLS, CELLS);
    end
  endfunction

  // expected result of one console command, updating the shadow state
  function automatic tcw_pkg::result_t console_step(
      input logic [tcw_pkg::KIND_W-1:0]  kind,
      input logic [tcw_pkg::CHAR_W-1:0]  code,
      input logic [tcw_pkg::INDEX_W-1:0] idx);
    tcw_pkg::result_t res;
    res = '0;
    case (kind)
      tcw_pkg::KIND_PUT: begin
        if (code == tcw_pkg::CHAR_NEWLINE) begin
          next_line();
        end else if (code == tcw_pkg::CHAR_BACKSPACE) begin
          // backspace stops at column zero
          if (cur_col > 0) begin
            cur_col--;
            shadow_screen[cur_row * COLS + cur_col] = {blank_attr, tcw_pkg::CHAR_SPACE};
          end
        end else begin
          shadow_screen[cur_row * COLS + cur_col] = {text_attr, code};
          cur_col++;
          if (cur_col >= COLS) next_line();
        end
      end
      tcw_pkg::KIND_CLEAR: begin
        blank_range(0, CELLS);
        cur_col = 0;
        cur_row = 0;
      end
      tcw_pkg::KIND_READ: begin
        if (idx < CELLS) res.cell_data = shadow_screen[idx];
      end
      default: ;
    endcase
    res.cursor_pos = tcw_pkg::POS_W'(cur_row * COLS + cur_col);
    return res;
  endfunction

  // offer one command and record its expected result at the transfer
  task automatic offer_item(input logic [tcw_pkg::KIND_W-1:0] kind,
                            input logic [tcw_pkg::CHAR_W-1:0] code,
                            input logic [tcw_pkg::INDEX_W-1:0] idx, input bit typed,
                            input tcw_pkg::result_t typed_res);
    int               gap;
    tcw_pkg::result_t predicted;
    gap = fast_mode ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {5'b0, idx, code};
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    predicted = console_step(kind, code, idx);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [tcw_pkg::ATTR_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == tcw_pkg::REG_TEXT_ATTR) text_attr = value;
    else blank_attr = value;
    @(posedge clk);
  endtask

  // result side: random stalls, a long hold now and then, field checks
  initial begin : result_sink
    int               gap;
    tcw_pkg::result_t want;
    wait (rst == 1'b0);
    forever begin
      if (results_seen % 600 == 200) gap = LONG_HOLD;
      else gap = fast_mode ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (m_tvalid !== 1'b1) @(posedge clk);
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result transfer with no command outstanding: m_tdata %h", m_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[10:0] !== want.cursor_pos) begin
          $error("cursor_pos: expected %0d, actual %0d", want.cursor_pos, m_tdata[10:0]);
          error_count++;
        end
        if (m_tdata[26:11] !== want.cell_data) begin
          $error("cell_data: expected %h, actual %h", want.cell_data, m_tdata[26:11]);
          error_count++;
        end
      end
    end
  end

  // stimulus
  initial begin : command_source
    logic [tcw_pkg::KIND_W-1:0]  kind;
    logic [tcw_pkg::CHAR_W-1:0]  code;
    logic [tcw_pkg::INDEX_W-1:0] idx;
    int                          nl_pct;
    int                          sel;
    int                          pos;

    text_attr  = tcw_pkg::RESET_TEXT_ATTR;
    blank_attr = tcw_pkg::RESET_BLANK_ATTR;
    blank_range(0, CELLS);
    cur_col = 0;
    cur_row = 0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed commands under reset attributes
    foreach (opening_items[i])
      offer_item(opening_items[i].kind, opening_items[i].code, opening_items[i].idx,
                 opening_items[i].typed, {opening_items[i].exp_cell, opening_items[i].pos});
    wait_drained();

    // random typing sessions, each under its own attributes
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(tcw_pkg::REG_TEXT_ATTR, 8'h00);
          write_reg(tcw_pkg::REG_BLANK_ATTR, 8'hFF);
        end
        1: begin
          write_reg(tcw_pkg::REG_BLANK_ATTR, 8'h00);
          write_reg(tcw_pkg::REG_TEXT_ATTR, 8'hFF);
        end
        3: begin
          write_reg(tcw_pkg::REG_TEXT_ATTR, tcw_pkg::RESET_TEXT_ATTR);
          write_reg(tcw_pkg::REG_BLANK_ATTR, tcw_pkg::RESET_BLANK_ATTR);
        end
        default: begin
          write_reg(tcw_pkg::REG_TEXT_ATTR, tcw_pkg::ATTR_W'($urandom));
          write_reg(tcw_pkg::REG_BLANK_ATTR, tcw_pkg::ATTR_W'($urandom));
        end
      endcase
      fast_mode = (phase == 1 || phase == 4);
      nl_pct = 10;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // newline density changes every few dozen commands
        if (n % 50 == 0) nl_pct = $urandom_range(0, 25);
        code = tcw_pkg::CHAR_W'($urandom_range(8'h21, 8'h7E));
        idx  = tcw_pkg::INDEX_W'($urandom);
        sel  = $urandom_range(0, 399);
        if (sel == 0) begin
          kind = tcw_pkg::KIND_CLEAR;
        end else if (sel < 5) begin
          kind = KIND_UNUSED;
        end else if (sel < 65) begin
          kind = tcw_pkg::KIND_READ;
          sel  = $urandom_range(0, 99);
          if (sel < 50) begin
            pos = cur_row * COLS + cur_col + int'($urandom_range(0, 6)) - 3;
            if (pos < 0) pos = 0;
            idx = tcw_pkg::INDEX_W'(pos);
          end else if (sel < 85) begin
            idx = tcw_pkg::INDEX_W'($urandom_range(0, CELLS - 1));
          end else if (sel < 95) begin
            idx = tcw_pkg::INDEX_W'($urandom_range(CELLS, 2047));
          end
        end else begin
          kind = tcw_pkg::KIND_PUT;
          sel  = $urandom_range(0, 99);
          if (sel < nl_pct) code = tcw_pkg::CHAR_NEWLINE;
          else if (sel < nl_pct + 8) code = tcw_pkg::CHAR_BACKSPACE;
          else if (sel < nl_pct + 18) code = tcw_pkg::CHAR_W'($urandom);
        end
        offer_item(kind, code, idx, 1'b0, '0);
        // occasional pause until the console has answered everything
        if ($urandom_range(0, 149) == 0) wait_drained();
      end
      wait_drained();
    end

    // let any stray result show up
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/tcw_ctrl.sv
hdl/text_console_writer_unit.sv
dv/tb_text_console_writer_unit.sv
